// ===== hw/rtl/phr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette HSV to RGB package
// Shared constants, the job type handed from front to back, and the small
// lookup functions for sector span, reciprocal and division by 255.
// ----------------------------------------------------------------------------
package phr_pkg;

	localparam int MaxColors  = 8;
	localparam int ColorIdxW  = $clog2(MaxColors);
	localparam int PairCount  = MaxColors / 2;
	localparam int PairIdxW   = $clog2(PairCount);
	localparam int CountW     = 4;
	localparam int PairW      = 48;
	localparam int CfgIdxW    = 3;
	localparam int ChanCount  = 3;
	localparam int PosW       = 7;
	localparam int RecipW     = 12;
	localparam int MagW       = 15;

	typedef logic [7:0] byte_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COLORS_TOTAL = 3'd0,
		REG_PAIR_0       = 3'd1,
		REG_PAIR_1       = 3'd2,
		REG_PAIR_2       = 3'd3,
		REG_PAIR_3       = 3'd4
	} reg_index_t;

	// One classified pixel: the two palette colors of its sector, the offset
	// inside the sector and the blend controls.
	typedef struct packed {
		byte_t [ChanCount-1:0] base_ch;
		byte_t [ChanCount-1:0] next_ch;
		logic [PosW-1:0]       pos;
		logic [CountW-1:0]     colors;
		byte_t                 sat;
		byte_t                 val;
	} job_t;

	// Hues per sector, 256 / n, for a clamped color count.
	function automatic byte_t span_of(input logic [CountW-1:0] n);
		byte_t s;
		case (n)
			4'd2: s = 8'd128;
			4'd3: s = 8'd85;
			4'd4: s = 8'd64;
			4'd5: s = 8'd51;
			4'd6: s = 8'd42;
			4'd7: s = 8'd36;
			default: s = 8'd32;
		endcase
		return s;
	endfunction

	// floor(65536 / span), used to estimate a quotient by the sector span.
	function automatic logic [RecipW-1:0] recip_of(input logic [CountW-1:0] n);
		logic [RecipW-1:0] r;
		case (n)
			4'd2: r = 12'd512;
			4'd3: r = 12'd771;
			4'd4: r = 12'd1024;
			4'd5: r = 12'd1285;
			4'd6: r = 12'd1560;
			4'd7: r = 12'd1820;
			default: r = 12'd2048;
		endcase
		return r;
	endfunction

	// Exact floor(x / 255) for any product of two bytes.
	function automatic byte_t div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/phr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette HSV to RGB front end
// Holds the configuration registers, finds the hue sector of each pixel and
// fetches the two palette colors that bound it.
// ----------------------------------------------------------------------------
module phr_front import phr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          hue,
	input  wire logic [7:0]          saturation,
	input  wire logic [7:0]          brightness,
	input  wire logic                cfg_write,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [PairW-1:0]    cfg_data,
	output logic                     job_valid_s1,
	output job_t                     job_s1
);

	logic [CountW-1:0]  colors_q;
	logic [PairW-1:0]   pal_q [PairCount];

	logic [CountW-1:0]  n_eff;
	byte_t              span;
	logic [ColorIdxW-1:0] sector;
	logic [10:0]        sector_base;
	byte_t              pos_full;
	logic [CountW-1:0]  base4;
	logic [CountW-1:0]  next4;
	logic [ColorIdxW-1:0] base_c;
	logic [ColorIdxW-1:0] next_c;
	logic [23:0]        base_word;
	logic [23:0]        next_word;
	job_t               job_d;

	function automatic logic [23:0] color_word(input logic [ColorIdxW-1:0] c,
	                                           input logic [PairW-1:0] pair);
		return c[0] ? pair[47:24] : pair[23:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= 4'd2;
			for (int i = 0; i < PairCount; i++) begin
				pal_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COLORS_TOTAL: colors_q <= cfg_data[CountW-1:0];
				REG_PAIR_0:       pal_q[0] <= cfg_data;
				REG_PAIR_1:       pal_q[1] <= cfg_data;
				REG_PAIR_2:       pal_q[2] <= cfg_data;
				REG_PAIR_3:       pal_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (colors_q < 4'd2) begin
			n_eff = 4'd2;
		end else if (colors_q > CountW'(MaxColors)) begin
			n_eff = CountW'(MaxColors);
		end else begin
			n_eff = colors_q;
		end
		span = span_of(n_eff);

		// Sector number by parallel compares against the sector boundaries.
		sector = '0;
		for (int k = 1; k < MaxColors; k++) begin
			if ({2'b00, hue} >= 10'(k) * {2'b00, span}) begin
				sector = sector + 1'b1;
			end
		end
		sector_base = 11'(sector) * {3'b000, span};
		pos_full = hue - sector_base[7:0];

		// A tail hue past the last full sector wraps its color index.
		base4 = ({1'b0, sector} >= n_eff) ? ({1'b0, sector} - n_eff) : {1'b0, sector};
		next4 = (base4 == n_eff - 4'd1) ? 4'd0 : base4 + 4'd1;
		base_c = base4[ColorIdxW-1:0];
		next_c = next4[ColorIdxW-1:0];
		base_word = color_word(base_c, pal_q[base_c[ColorIdxW-1:1]]);
		next_word = color_word(next_c, pal_q[next_c[ColorIdxW-1:1]]);

		job_d.pos    = pos_full[PosW-1:0];
		job_d.colors = n_eff;
		job_d.sat    = saturation;
		job_d.val    = brightness;
		for (int ch = 0; ch < ChanCount; ch++) begin
			job_d.base_ch[ch] = base_word[8*(2-ch) +: 8];
			job_d.next_ch[ch] = next_word[8*(2-ch) +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else begin
			job_valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= job_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/phr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette HSV to RGB job queue
// Two-entry queue of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module phr_queue import phr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  job_t       push_job,
	input  wire logic  pop,
	output logic       deq_valid,
	output job_t       deq_job,
	output logic       full
);

	job_t        mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign deq_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign deq_job   = mem_q[rp_q];
	assign do_pop    = pop && deq_valid;
	assign do_push   = push && (!full || do_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/phr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette HSV to RGB back end
// Six-stage pipeline: sector interpolation, white blend by saturation and
// scaling by brightness, for all three channels side by side.
// ----------------------------------------------------------------------------
module phr_back import phr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  job_t                   job,
	output logic                   result_valid,
	output byte_t [ChanCount-1:0]  rgb
);

	// Stage 1: magnitude of (next - base) * pos.
	logic                  v_s1;
	logic [MagW-1:0]       mag_s1 [ChanCount];
	logic                  neg_s1 [ChanCount];
	byte_t                 base_s1 [ChanCount];
	logic [CountW-1:0]     colors_s1;
	byte_t                 sat_s1;
	byte_t                 val_s1;

	// Stage 2: quotient estimate through the reciprocal.
	logic                  v_s2;
	byte_t                 q0_s2 [ChanCount];
	logic [MagW-1:0]       mag_s2 [ChanCount];
	logic                  neg_s2 [ChanCount];
	byte_t                 base_s2 [ChanCount];
	logic [CountW-1:0]     colors_s2;
	byte_t                 sat_s2;
	byte_t                 val_s2;

	// Stage 3: interpolated channel.
	logic                  v_s3;
	byte_t                 c_s3 [ChanCount];
	byte_t                 sat_s3;
	byte_t                 val_s3;

	// Stage 4: (255 - c) * saturation.
	logic                  v_s4;
	logic [15:0]           x_s4 [ChanCount];
	byte_t                 val_s4;

	// Stage 5: blended channel times brightness.
	logic                  v_s5;
	logic [15:0]           y_s5 [ChanCount];

	logic                  v_s6;
	byte_t                 out_s6 [ChanCount];

	logic [26:0]           est_prod [ChanCount];
	logic [15:0]           back_prod [ChanCount];
	logic [15:0]           rem [ChanCount];
	byte_t                 q_fix [ChanCount];
	byte_t                 span_s2;
	byte_t                 dmag [ChanCount];

	always_comb begin
		span_s2 = span_of(colors_s2);
		for (int ch = 0; ch < ChanCount; ch++) begin
			dmag[ch] = (job.next_ch[ch] < job.base_ch[ch]) ?
				(job.base_ch[ch] - job.next_ch[ch]) : (job.next_ch[ch] - job.base_ch[ch]);
			est_prod[ch] = 27'(mag_s1[ch]) * 27'(recip_of(colors_s1));
			back_prod[ch] = 16'(q0_s2[ch]) * 16'(span_s2);
			rem[ch] = 16'(mag_s2[ch]) - back_prod[ch];
			q_fix[ch] = (rem[ch] >= 16'(span_s2)) ? q0_s2[ch] + 8'd1 : q0_s2[ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		colors_s1 <= job.colors;
		sat_s1    <= job.sat;
		val_s1    <= job.val;
		colors_s2 <= colors_s1;
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;
		sat_s3    <= sat_s2;
		val_s3    <= val_s2;
		val_s4    <= val_s3;
		for (int ch = 0; ch < ChanCount; ch++) begin
			mag_s1[ch]  <= 15'(dmag[ch]) * 15'(job.pos);
			neg_s1[ch]  <= (job.next_ch[ch] < job.base_ch[ch]);
			base_s1[ch] <= job.base_ch[ch];

			q0_s2[ch]   <= est_prod[ch][23:16];
			mag_s2[ch]  <= mag_s1[ch];
			neg_s2[ch]  <= neg_s1[ch];
			base_s2[ch] <= base_s1[ch];

			c_s3[ch] <= neg_s2[ch] ? base_s2[ch] - q_fix[ch] : base_s2[ch] + q_fix[ch];

			x_s4[ch] <= 16'(8'd255 - c_s3[ch]) * 16'(sat_s3);

			y_s5[ch] <= 16'(8'd255 - div255(x_s4[ch])) * 16'(val_s4);

			out_s6[ch] <= div255(y_s5[ch]);
		end
	end

	assign result_valid = v_s6;
	always_comb begin
		for (int ch = 0; ch < ChanCount; ch++) begin
			rgb[ch] = out_s6[ch];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/palette_hsv_to_rgb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette HSV to RGB converter
// Maps hue, saturation and brightness bytes to RGB bytes through a
// programmable palette of two to eight colors.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock cycle and returns one RGB pixel for
// each, in order: a request is registered in the front end, passes the job
// queue and the back-end stages, and the last stage drives result_valid.
// The receiver cannot hold results off, so every result is on red, green
// and blue for exactly one cycle and must be captured then.
// The throughput is set by the back-end pipeline, which starts a new pixel
// in every stage on every cycle; busy only rises if the job queue between
// the front and back ends fills, which does not happen in steady operation.
//
// The hue ring of 256 steps is cut into equal sectors, one per palette
// color, each 256 / colors_total hues wide. Inside a sector every channel
// moves linearly from that sector's color toward the next one, and the last
// sector wraps back to color 0. Hues in the short tail past the last full
// sector reuse the colors from the start of the palette. Saturation then
// pulls the color toward white and brightness scales it toward black, both
// with truncating division by 255.
//
// Configuration uses its own write channel, which is always ready. Index 0
// holds colors_total (values below 2 act as 2, above 8 as 8), and indices 1
// to 4 each hold a pair of 24-bit colors, the even color in the low half and
// each color packed as red, green, blue from the top byte down. Writes to
// other indices are dropped. Change the configuration only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module palette_hsv_to_rgb_core import phr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                start,
	output logic                     busy,
	input  wire logic [7:0]          hue,
	input  wire logic [7:0]          saturation,
	input  wire logic [7:0]          brightness,

	output logic                     result_valid,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue,

	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [PairW-1:0]    cfg_data
);

	logic                  take;
	logic                  job_valid_s1;
	job_t                  job_s1;
	logic                  deq_valid;
	job_t                  deq_job;
	logic                  queue_full;
	byte_t [ChanCount-1:0] rgb;

	// A request is taken whenever the queue has room.
	assign take      = start && !busy;
	assign busy      = queue_full;
	assign cfg_ready = 1'b1;

	phr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1)
	);

	// The back end never stalls, so the queue drains every cycle it holds
	// a job.
	phr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid_s1),
		.push_job  (job_s1),
		.pop       (1'b1),
		.deq_valid (deq_valid),
		.deq_job   (deq_job),
		.full      (queue_full)
	);

	phr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (deq_valid),
		.job          (deq_job),
		.result_valid (result_valid),
		.rgb          (rgb)
	);

	assign red   = rgb[0];
	assign green = rgb[1];
	assign blue  = rgb[2];

endmodule
`default_nettype wire
